[rtl/mcvs_pkg.sv]
// Package for the clock second-chance victim selector.
// Holds beat types, opcodes, defaults and the controller/datapath structs.
// No dependencies.
package mcvs_pkg;

  localparam int WaysDefault      = 8;
  localparam int StampBitsDefault = 32;
  localparam int CfgW             = 4;
  localparam logic [CfgW-1:0] WaysInUseRst = 4'd8;

  localparam logic [1:0] OpTouch  = 2'd0;
  localparam logic [1:0] OpInval  = 2'd1;
  localparam logic [1:0] OpVictim = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  way_index;
    logic [31:0] now;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] victim_way;
    logic       chose_invalid;
  } out_beat_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic sweep;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic found_invalid;
    logic scan_end;
    logic sweep_hit;
  } dp_stat_t;

endpackage

[rtl/mru_start_clock_victim_select.sv]
// Top level of the clock second-chance victim selector for one cache set.
// Instantiates mcvs_ctrl and mcvs_datapath; depends on mcvs_pkg.
//
// A touch, invalidate or unused opcode returns a zero result beat. A
// victim request first streams the stamps of the n ways in use through
// the registered read port of the stamp memory, one way a cycle, and
// stops early if an invalid way turns up; else it sweeps the reference
// bits one way a cycle. Last it loads the result, waiting while the
// output is stalled. One item is in work at a time; the input is stalled
// while a victim request is running. The valid and reference bits are
// cleared at once by reset, so no item waits on a clearing pass.
module mru_start_clock_victim_select #(
  parameter int WAYS       = mcvs_pkg::WaysDefault,
  parameter int STAMP_BITS = mcvs_pkg::StampBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mcvs_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  mcvs_pkg::in_beat_t        in_beat_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output mcvs_pkg::out_beat_t       out_beat_o
);

  mcvs_pkg::ctl_cmd_t cmd;
  mcvs_pkg::dp_stat_t stat;

  mcvs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (in_beat_i.opcode),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  mcvs_datapath #(
    .WAYS       (WAYS),
    .STAMP_BITS (STAMP_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_beat_i   (in_beat_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_beat_o  (out_beat_o)
  );

  a_plain_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && in_beat_i.opcode != mcvs_pkg::OpVictim) |=>
      (out_valid_o && out_beat_o.victim_way == '0 && !out_beat_o.chose_invalid))
    else $error("plain beat did not yield a zero result");

  a_victim_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && in_beat_i.opcode == mcvs_pkg::OpVictim) |=> in_stall_o)
    else $error("input taken while a victim request is running");

  a_invalid_skips_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.scan && stat.found_invalid) |=> (!cmd.sweep && !cmd.scan))
    else $error("sweep entered after an invalid way was found");

endmodule

[rtl/mcvs_ctrl.sv]
// Controller state machine for the victim selector.
// Sequences scan, sweep and result hand-off; depends on mcvs_pkg.
module mcvs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          opcode_i,
  input  logic                out_stall_i,
  input  mcvs_pkg::dp_stat_t  stat_i,
  output mcvs_pkg::ctl_cmd_t  cmd_o,
  output logic                in_stall_o,
  output logic                out_valid_o
);

  typedef enum logic [1:0] {StIdle, StScan, StSweep, StFinish} st_e;

  st_e  state_q;
  logic out_vld_q;
  logic out_free;

  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    cmd_o.accept = (state_q == StIdle) && out_free && in_valid_i;
    cmd_o.scan   = (state_q == StScan);
    cmd_o.sweep  = (state_q == StSweep);
    cmd_o.finish = (state_q == StFinish) && out_free;
  end

  assign in_stall_o  = !((state_q == StIdle) && out_free);
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      out_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (cmd_o.accept) begin
            if (opcode_i == mcvs_pkg::OpVictim) begin
              state_q <= StScan;
            end else begin
              out_vld_q <= 1'b1;
            end
          end
        end
        StScan: begin
          if (stat_i.found_invalid) begin
            state_q <= StFinish;
          end else if (stat_i.scan_end) begin
            state_q <= StSweep;
          end
        end
        StSweep: begin
          if (stat_i.sweep_hit) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            state_q   <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

[rtl/mcvs_datapath.sv]
// Datapath of the victim selector: stamp memory, live and reference bits,
// scan and sweep registers and the result payload; depends on mcvs_pkg.
module mcvs_datapath #(
  parameter int WAYS       = mcvs_pkg::WaysDefault,
  parameter int STAMP_BITS = mcvs_pkg::StampBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mcvs_pkg::CfgW-1:0] cfg_wdata_i,
  input  mcvs_pkg::in_beat_t        in_beat_i,
  input  mcvs_pkg::ctl_cmd_t        cmd_i,
  output mcvs_pkg::dp_stat_t        stat_o,
  output mcvs_pkg::out_beat_t       out_beat_o
);

  localparam int WayW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NW   = $clog2(WAYS + 1);

  logic [STAMP_BITS-1:0] mem [WAYS];

  logic [mcvs_pkg::CfgW-1:0] ways_q;
  logic [WAYS-1:0]           live_q;
  logic [WAYS-1:0]           ref_q;
  logic [NW-1:0]             issue_q;
  logic                      cmp_vld_q;
  logic                      inv_flag_q;
  logic [WayW-1:0]           cmp_idx_q;
  logic [WayW-1:0]           pos_q;
  logic [STAMP_BITS-1:0]     rd_data_q;
  logic [STAMP_BITS-1:0]     max_q;
  logic [2:0]                res_way_q;
  logic                      res_inv_q;

  logic                  way_ok;
  logic [WayW-1:0]       wr_idx;
  logic [STAMP_BITS-1:0] stamp_in;
  logic                  is_touch;
  logic                  is_inval;
  logic                  is_victim;
  logic                  mem_we;
  logic [NW-1:0]         n_ways;
  logic                  issue_more;
  logic [WayW-1:0]       rd_addr;
  logic                  cmp_live;
  logic                  cmp_better;
  logic                  last_idx;
  logic [NW-1:0]         pos_inc;
  logic [WayW-1:0]       pos_next;

  assign way_ok    = 32'(in_beat_i.way_index) < 32'(WAYS);
  assign wr_idx    = WayW'(in_beat_i.way_index);
  assign stamp_in  = STAMP_BITS'(in_beat_i.now);
  assign is_touch  = in_beat_i.opcode == mcvs_pkg::OpTouch;
  assign is_inval  = in_beat_i.opcode == mcvs_pkg::OpInval;
  assign is_victim = in_beat_i.opcode == mcvs_pkg::OpVictim;
  assign mem_we    = cmd_i.accept && is_touch && way_ok;

  always_comb begin
    if (ways_q == '0) begin
      n_ways = NW'(1);
    end else if (32'(ways_q) > 32'(WAYS)) begin
      n_ways = NW'(WAYS);
    end else begin
      n_ways = NW'(ways_q);
    end
  end

  assign issue_more = issue_q < n_ways;
  assign rd_addr    = issue_q[WayW-1:0];
  assign cmp_live   = live_q[cmp_idx_q];
  assign cmp_better = (cmp_idx_q == '0) || (rd_data_q > max_q);
  assign last_idx   = NW'(cmp_idx_q) == (n_ways - 1'b1);
  assign pos_inc    = NW'(pos_q) + 1'b1;
  assign pos_next   = (pos_inc < n_ways) ? pos_inc[WayW-1:0] : '0;

  always_comb begin
    stat_o.found_invalid = cmp_vld_q && !cmp_live;
    stat_o.scan_end      = cmp_vld_q && cmp_live && last_idx;
    stat_o.sweep_hit     = !ref_q[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_idx] <= stamp_in;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q     <= mcvs_pkg::WaysInUseRst;
      live_q     <= '0;
      ref_q      <= '0;
      issue_q    <= '0;
      cmp_vld_q  <= 1'b0;
      inv_flag_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ways_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        if (is_touch && way_ok) begin
          live_q[wr_idx] <= stamp_in != '0;
          ref_q[wr_idx]  <= 1'b1;
        end
        if (is_inval && way_ok) begin
          live_q[wr_idx] <= 1'b0;
          ref_q[wr_idx]  <= 1'b0;
        end
        if (is_victim) begin
          issue_q    <= '0;
          cmp_vld_q  <= 1'b0;
          inv_flag_q <= 1'b0;
        end
      end
      if (cmd_i.scan) begin
        cmp_vld_q <= issue_more;
        if (issue_more) begin
          issue_q <= issue_q + 1'b1;
        end
        if (stat_o.found_invalid) begin
          inv_flag_q <= 1'b1;
        end
      end
      if (cmd_i.sweep && !stat_o.sweep_hit) begin
        ref_q[pos_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      cmp_idx_q <= rd_addr;
      if (cmp_vld_q) begin
        if (!cmp_live) begin
          pos_q <= cmp_idx_q;
        end else if (cmp_better) begin
          pos_q <= cmp_idx_q;
          max_q <= rd_data_q;
        end
      end
    end
    if (cmd_i.sweep && !stat_o.sweep_hit) begin
      pos_q <= pos_next;
    end
    if (cmd_i.accept && !is_victim) begin
      res_way_q <= '0;
      res_inv_q <= 1'b0;
    end
    if (cmd_i.finish) begin
      res_way_q <= 3'(pos_q);
      res_inv_q <= inv_flag_q;
    end
  end

  always_comb begin
    out_beat_o.victim_way    = res_way_q;
    out_beat_o.chose_invalid = res_inv_q;
  end

endmodule
